// ===== design/bq3i_pkg.sv =====
// Shared constants, widths and types of the biquadratic 3x3 interpolator.
`timescale 1ns / 1ps
`default_nettype none
package bq3i_pkg;

  localparam int PIXEL_BITS      = 16;
  localparam int SHIFT_FRAC_BITS = 14;

  // Fixed field and bus widths.
  localparam int FIELD_W     = 16;
  localparam int OUT_FIELD_W = 18;
  localparam int S_TDATA_W   = 11 * FIELD_W;
  localparam int M_TDATA_W   = ((OUT_FIELD_W + 7) / 8) * 8;
  localparam int NUM_STAGES  = 7;

  // Clamped shift holds -2^F .. +2^F.
  localparam int SHIFT_W = SHIFT_FRAC_BITS + 2;
  localparam int CMP_W   = (FIELD_W > SHIFT_W) ? FIELD_W : SHIFT_W;
  localparam int SS_W    = 2 * SHIFT_FRAC_BITS + 1;

  // Column lane widths.
  localparam int D2_W = PIXEL_BITS + 2;
  localparam int D1_W = PIXEL_BITS + 1;
  localparam int P2_W = D2_W + SS_W + 1;
  localparam int Q2_W = D1_W + SHIFT_W;
  localparam int V_W  = PIXEL_BITS + SHIFT_FRAC_BITS + 4;

  // Row merge widths.
  localparam int E2_W  = V_W + 2;
  localparam int E1_W  = V_W + 1;
  localparam int M5_W  = E2_W + SHIFT_W;
  localparam int R1_W  = M5_W - SHIFT_FRAC_BITS;
  localparam int A_W   = R1_W + SHIFT_W;
  localparam int B_W   = E1_W + SHIFT_W;
  localparam int N_W   = A_W + 1;
  localparam int RES_W = N_W - (2 * SHIFT_FRAC_BITS + 2);
  localparam int OUT_W = PIXEL_BITS + 2;

  typedef logic signed [SHIFT_W-1:0] shift_t;
  typedef logic        [PIXEL_BITS-1:0] pixel_t;
  typedef logic signed [V_W-1:0] colval_t;
  typedef logic signed [OUT_W-1:0] result_t;

  // Per-stage advance strobes handed from the pipeline control to the datapath.
  typedef struct packed {
    logic col_prep;
    logic col_mul;
    logic col_sum;
    logic row_diff;
    logic row_mul;
    logic row_fin;
  } stage_en_t;

endpackage
`default_nettype wire

// ===== design/bq3i_col_lane.sv =====
// One column lane: quadratic fit through a column and evaluation at the vertical shift.
`timescale 1ns / 1ps
`default_nettype none
module bq3i_col_lane (
  input  wire                                     clk_i,
  input  bq3i_pkg::stage_en_t                     en_i,
  input  bq3i_pkg::pixel_t                        top_i,
  input  bq3i_pkg::pixel_t                        mid_i,
  input  bq3i_pkg::pixel_t                        bot_i,
  input  bq3i_pkg::shift_t                        sy_i,
  input  wire logic [bq3i_pkg::SS_W-1:0]          ss_i,
  output bq3i_pkg::colval_t                       v_o
);

  localparam int F  = bq3i_pkg::SHIFT_FRAC_BITS;
  localparam logic signed [bq3i_pkg::P2_W-1:0] HALF =
    bq3i_pkg::P2_W'(1) << (F - 1);

  logic signed [bq3i_pkg::D2_W-1:0] d2_d, d2_q;
  logic signed [bq3i_pkg::D1_W-1:0] d1_d, d1_q;
  bq3i_pkg::pixel_t                 m1_q, m2_q;
  logic signed [bq3i_pkg::P2_W-1:0] p2_d, p2_q;
  logic signed [bq3i_pkg::Q2_W-1:0] q2_d, q2_q;
  bq3i_pkg::colval_t                v_d, v_q;
  logic signed [bq3i_pkg::P2_W-1:0] p2_rnd;

  // Second difference t + u - 2m and first difference u - t.
  assign d2_d = $signed({2'b00, top_i}) + $signed({2'b00, bot_i})
              - $signed({1'b0, mid_i, 1'b0});
  assign d1_d = $signed({1'b0, bot_i}) - $signed({1'b0, top_i});

  assign p2_d = d2_q * $signed({1'b0, ss_i});
  assign q2_d = d1_q * sy_i;

  assign p2_rnd = (p2_q + HALF) >>> F;
  assign v_d = bq3i_pkg::V_W'(p2_rnd) + bq3i_pkg::V_W'(q2_q)
             + $signed(bq3i_pkg::V_W'({1'b0, m2_q, {(F + 1){1'b0}}}));

  always_ff @(posedge clk_i) begin
    if (en_i.col_prep) begin
      d2_q <= d2_d;
      d1_q <= d1_d;
      m1_q <= mid_i;
    end
    if (en_i.col_mul) begin
      p2_q <= p2_d;
      q2_q <= q2_d;
      m2_q <= m1_q;
    end
    if (en_i.col_sum) begin
      v_q <= v_d;
    end
  end

  assign v_o = v_q;

endmodule
`default_nettype wire

// ===== design/bq3i_row_merge.sv =====
// Row merge: quadratic fit across the three column results at the horizontal shift.
`timescale 1ns / 1ps
`default_nettype none
module bq3i_row_merge (
  input  wire                  clk_i,
  input  bq3i_pkg::stage_en_t  en_i,
  input  bq3i_pkg::colval_t    v0_i,
  input  bq3i_pkg::colval_t    v1_i,
  input  bq3i_pkg::colval_t    v2_i,
  input  bq3i_pkg::shift_t     sx_i,
  output bq3i_pkg::result_t    res_o
);

  localparam int F  = bq3i_pkg::SHIFT_FRAC_BITS;
  localparam int P  = bq3i_pkg::PIXEL_BITS;
  localparam int FS = 2 * F + 2;
  localparam logic signed [bq3i_pkg::M5_W-1:0] HALF5 = bq3i_pkg::M5_W'(1) << (F - 1);
  localparam logic signed [bq3i_pkg::N_W-1:0]  HALFN = bq3i_pkg::N_W'(1) << (FS - 1);
  localparam logic signed [bq3i_pkg::RES_W-1:0] HI =
    bq3i_pkg::RES_W'((1 << (P + 1)) - 1);
  localparam logic signed [bq3i_pkg::RES_W-1:0] LO = -(bq3i_pkg::RES_W'(1) << P);

  logic signed [bq3i_pkg::E2_W-1:0]  e2_d, e2_q;
  logic signed [bq3i_pkg::E1_W-1:0]  e1_d, e1_q;
  bq3i_pkg::colval_t                 c4_q, c5_q;
  bq3i_pkg::shift_t                  sx4_q, sx5_q;
  logic signed [bq3i_pkg::M5_W-1:0]  m5_d, m5_q, m5_rnd;
  logic signed [bq3i_pkg::B_W-1:0]   b5_d, b5_q;
  logic signed [bq3i_pkg::R1_W-1:0]  r1;
  logic signed [bq3i_pkg::A_W-1:0]   a6_d, a6_q;
  logic signed [bq3i_pkg::N_W-1:0]   bc6_d, bc6_q, n_sum, n_rnd;
  logic signed [bq3i_pkg::RES_W-1:0] res_full;

  assign e2_d = bq3i_pkg::E2_W'(v0_i) + bq3i_pkg::E2_W'(v2_i)
              - (bq3i_pkg::E2_W'(v1_i) <<< 1);
  assign e1_d = bq3i_pkg::E1_W'(v2_i) - bq3i_pkg::E1_W'(v0_i);

  assign m5_d = e2_q * sx4_q;
  assign b5_d = e1_q * sx4_q;

  // Round the curvature product, then scale by the shift a second time.
  assign m5_rnd = (m5_q + HALF5) >>> F;
  assign r1     = bq3i_pkg::R1_W'(m5_rnd);
  assign a6_d   = r1 * sx5_q;
  assign bc6_d  = bq3i_pkg::N_W'(b5_q) + (bq3i_pkg::N_W'(c5_q) <<< (F + 1));

  assign n_sum    = bq3i_pkg::N_W'(a6_q) + bc6_q;
  assign n_rnd    = (n_sum + HALFN) >>> FS;
  assign res_full = bq3i_pkg::RES_W'(n_rnd);

  always_comb begin
    priority if (res_full > HI) begin
      res_o = bq3i_pkg::OUT_W'(HI);
    end else if (res_full < LO) begin
      res_o = bq3i_pkg::OUT_W'(LO);
    end else begin
      res_o = bq3i_pkg::OUT_W'(res_full);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.row_diff) begin
      e2_q  <= e2_d;
      e1_q  <= e1_d;
      c4_q  <= v1_i;
      sx4_q <= sx_i;
    end
    if (en_i.row_mul) begin
      m5_q  <= m5_d;
      b5_q  <= b5_d;
      c5_q  <= c4_q;
      sx5_q <= sx4_q;
    end
    if (en_i.row_fin) begin
      a6_q  <= a6_d;
      bc6_q <= bc6_d;
    end
  end

endmodule
`default_nettype wire

// ===== design/biquadratic_3x3_interpolator_unit.sv =====
// Top level of the biquadratic 3x3 interpolator: stream ports, pipeline control, lanes.
// Pipeline: a request accepted at a clock edge passes seven register stages, the
// first loaded at the accepting edge, before its result shows on m_axis_tvalid_o
// when nothing stalls.
// Throughput: one request per cycle; every stage is fully pipelined and items are
// independent, so the rate is set only by the output handshake.
// Reset: rst_ni clears the stage valid bits at once; datapath registers are not reset.
`timescale 1ns / 1ps
`default_nettype none
module biquadratic_3x3_interpolator_unit (
  input  wire                                   clk_i,
  input  wire                                   rst_ni,
  // Input stream. tdata fields from bit 0 up: x_shift, y_shift, p_r0c0, p_r0c1,
  // p_r0c2, p_r1c0, p_r1c1, p_r1c2, p_r2c0, p_r2c1, p_r2c2 (16 bits each).
  input  wire                                   s_axis_tvalid_i,
  output logic                                  s_axis_tready_o,
  input  wire  [bq3i_pkg::S_TDATA_W-1:0]        s_axis_tdata_i,
  // Output stream. tdata fields from bit 0 up: interpolated_value (18 bits signed),
  // then zero padding to a whole byte.
  output logic                                  m_axis_tvalid_o,
  input  wire                                   m_axis_tready_i,
  output logic [bq3i_pkg::M_TDATA_W-1:0]        m_axis_tdata_o
);

  localparam int NS = bq3i_pkg::NUM_STAGES;
  localparam int F  = bq3i_pkg::SHIFT_FRAC_BITS;
  localparam int FW = bq3i_pkg::FIELD_W;
  localparam logic signed [bq3i_pkg::CMP_W-1:0] ONE_C = bq3i_pkg::CMP_W'(1) <<< F;

  // Each stage holds a valid bit. A stage advances when it is empty or when the
  // stage after it advances, so bubbles collapse and the input keeps flowing while
  // a finished result waits in the output register, until all stages are full.
  logic [NS:1] vld_q, vld_d, adv;
  logic        s_fire;

  bq3i_pkg::stage_en_t en;

  bq3i_pkg::shift_t sx_c, sy_c;
  bq3i_pkg::shift_t sx1_q, sx2_q, sx3_q, sy1_q;
  logic signed [2*bq3i_pkg::SHIFT_W-1:0] ss_full;
  logic [bq3i_pkg::SS_W-1:0]             ss1_q;

  bq3i_pkg::pixel_t  pix [9];
  bq3i_pkg::colval_t col_v [3];
  bq3i_pkg::result_t res_c, out_q;

  // Shifts beyond plus or minus one are pinned to the nearer end.
  function automatic bq3i_pkg::shift_t clamp_shift(input logic [FW-1:0] raw);
    logic signed [bq3i_pkg::CMP_W-1:0] s;
    s = bq3i_pkg::CMP_W'($signed(raw));
    priority if (s > ONE_C) begin
      return bq3i_pkg::SHIFT_W'(ONE_C);
    end else if (s < -ONE_C) begin
      return bq3i_pkg::SHIFT_W'(-ONE_C);
    end else begin
      return bq3i_pkg::SHIFT_W'(s);
    end
  endfunction

  always_comb begin
    adv[NS] = !vld_q[NS] || m_axis_tready_i;
    for (int k = NS - 1; k >= 1; k--) begin
      adv[k] = !vld_q[k] || adv[k+1];
    end
  end

  always_comb begin
    vld_d[1] = adv[1] ? s_axis_tvalid_i : vld_q[1];
    for (int k = 2; k <= NS; k++) begin
      vld_d[k] = adv[k] ? vld_q[k-1] : vld_q[k];
    end
  end

  assign s_axis_tready_o = adv[1];
  assign s_fire          = s_axis_tvalid_i && s_axis_tready_o;

  assign en.col_prep = adv[1];
  assign en.col_mul  = adv[2];
  assign en.col_sum  = adv[3];
  assign en.row_diff = adv[4];
  assign en.row_mul  = adv[5];
  assign en.row_fin  = adv[6];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  // Shift preparation: clamp both shifts and square the vertical one for the lanes.
  assign sx_c    = clamp_shift(s_axis_tdata_i[0 +: FW]);
  assign sy_c    = clamp_shift(s_axis_tdata_i[FW +: FW]);
  assign ss_full = sy_c * sy_c;

  always_ff @(posedge clk_i) begin
    if (adv[1]) begin
      sx1_q <= sx_c;
      sy1_q <= sy_c;
      ss1_q <= bq3i_pkg::SS_W'(ss_full);
    end
    if (adv[2]) begin
      sx2_q <= sx1_q;
    end
    if (adv[3]) begin
      sx3_q <= sx2_q;
    end
    if (adv[NS]) begin
      out_q <= res_c;
    end
  end

  // Window pixels, row-major, masked or widened to the pixel width.
  for (genvar i = 0; i < 9; i++) begin : g_pix
    assign pix[i] = bq3i_pkg::PIXEL_BITS'(s_axis_tdata_i[2*FW + i*FW +: FW]);
  end

  // Three column lanes work side by side on the left, center and right columns.
  for (genvar k = 0; k < 3; k++) begin : g_lane
    bq3i_col_lane u_lane (
      .clk_i (clk_i),
      .en_i  (en),
      .top_i (pix[k]),
      .mid_i (pix[3+k]),
      .bot_i (pix[6+k]),
      .sy_i  (sy1_q),
      .ss_i  (ss1_q),
      .v_o   (col_v[k])
    );
  end

  bq3i_row_merge u_merge (
    .clk_i (clk_i),
    .en_i  (en),
    .v0_i  (col_v[0]),
    .v1_i  (col_v[1]),
    .v2_i  (col_v[2]),
    .sx_i  (sx3_q),
    .res_o (res_c)
  );

  // The pad bits above the signed value are zero, not copies of its sign.
  assign m_axis_tvalid_o = vld_q[NS];
  assign m_axis_tdata_o  = bq3i_pkg::M_TDATA_W'($unsigned(out_q));

  // The input is refused only when every stage is full and the output is stalled.
  a_ready_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> ((&vld_q) && !m_axis_tready_i))
    else $error("input stalled while the pipeline has room");

  // A full stage that cannot advance keeps its request.
  a_stalled_stage_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((vld_q & ~adv) != '0) |=> ((vld_q & $past(vld_q & ~adv)) == $past(vld_q & ~adv)))
    else $error("stalled pipeline stage lost its request");

  // An accepted request always lands in the first stage.
  a_accept_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_fire |=> vld_q[1])
    else $error("accepted request not captured by the first stage");

endmodule
`default_nettype wire

// ===== sim/biquadratic_3x3_interpolator_unit_tb.sv =====
// Self-checking testbench for the biquadratic 3x3 interpolator stream unit.
`timescale 1ns / 1ps
module biquadratic_3x3_interpolator_unit_tb;
  import bq3i_pkg::*;

  // One request as it travels on s_axis_tdata_i. A packed struct puts its first
  // member in the top bits, so the members are listed from the highest field down.
  typedef struct packed {
    logic        [FIELD_W-1:0] p_r2c2;
    logic        [FIELD_W-1:0] p_r2c1;
    logic        [FIELD_W-1:0] p_r2c0;
    logic        [FIELD_W-1:0] p_r1c2;
    logic        [FIELD_W-1:0] p_r1c1;
    logic        [FIELD_W-1:0] p_r1c0;
    logic        [FIELD_W-1:0] p_r0c2;
    logic        [FIELD_W-1:0] p_r0c1;
    logic        [FIELD_W-1:0] p_r0c0;
    logic signed [FIELD_W-1:0] y_shift;
    logic signed [FIELD_W-1:0] x_shift;
  } window_t;

  typedef logic [OUT_FIELD_W-1:0] pix_out_t;

  localparam int  RANDOM_ITEMS  = 1200;
  localparam int  PHASE_ITEMS   = 410;
  localparam int  DRAIN_CYCLES  = 3 * NUM_STAGES;
  localparam int  CYCLE_LIMIT   = 200000;
  localparam int  MAX_REPORTS   = 10;
  localparam int  PIX_MAX       = (1 << PIXEL_BITS) - 1;
  localparam int  SHIFT_ONE     = 1 << SHIFT_FRAC_BITS;
  localparam int  SHIFT_HALF    = SHIFT_ONE / 2;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 s_axis_tvalid_i;
  logic                 s_axis_tready_o;
  logic [S_TDATA_W-1:0] s_axis_tdata_i;
  logic                 m_axis_tvalid_o;
  logic                 m_axis_tready_i;
  logic [M_TDATA_W-1:0] m_axis_tdata_o;

  // Windows still to be offered, and interpolated pixels still to arrive.
  window_t  window_q[$];
  pix_out_t interp_q[$];

  int unsigned accept_cnt;
  int unsigned fail_cnt;
  int unsigned cycle_cnt;

  biquadratic_3x3_interpolator_unit dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // ---------------------------------------------------------------------------
  // Predictor. All arithmetic runs in 64-bit signed integers, which hold every
  // intermediate term with room to spare for 16-bit pixels and Q1.14 shifts.
  // ---------------------------------------------------------------------------

  // Round to nearest at bit k, halves going toward plus infinity. An arithmetic
  // right shift of a signed value is a floor division by a power of two.
  function automatic longint round_half_up(longint x, int k);
    return (x + (longint'(1) <<< (k - 1))) >>> k;
  endfunction

  // Shifts outside minus one to plus one are pinned to the nearer end.
  function automatic longint clamp_shift(logic signed [FIELD_W-1:0] raw);
    longint s;
    s = longint'(raw);
    if (s > SHIFT_ONE) s = SHIFT_ONE;
    if (s < -SHIFT_ONE) s = -SHIFT_ONE;
    return s;
  endfunction

  // Twice the vertical quadratic through top, middle and bottom, taken at the
  // shift, in units of 2^-F.
  function automatic longint column_twice(longint top, longint mid, longint bot, longint s);
    longint curv;
    longint slope;
    curv  = top + bot - 2 * mid;
    slope = bot - top;
    return round_half_up(curv * s * s, SHIFT_FRAC_BITS) + slope * s
           + mid * (longint'(1) <<< (SHIFT_FRAC_BITS + 1));
  endfunction

  function automatic pix_out_t interp_predict(window_t w);
    longint sx;
    longint sy;
    longint p[9];
    longint v[3];
    longint n;
    longint r;
    longint lo;
    longint hi;
    sx = clamp_shift(w.x_shift);
    sy = clamp_shift(w.y_shift);
    p[0] = longint'(w.p_r0c0);
    p[1] = longint'(w.p_r0c1);
    p[2] = longint'(w.p_r0c2);
    p[3] = longint'(w.p_r1c0);
    p[4] = longint'(w.p_r1c1);
    p[5] = longint'(w.p_r1c2);
    p[6] = longint'(w.p_r2c0);
    p[7] = longint'(w.p_r2c1);
    p[8] = longint'(w.p_r2c2);
    for (int i = 0; i < 3; i++) begin
      v[i] = column_twice(p[i], p[3 + i], p[6 + i], sy);
    end
    // Horizontal fit through the three doubled column values.
    n = round_half_up((v[0] + v[2] - 2 * v[1]) * sx, SHIFT_FRAC_BITS) * sx
        + (v[2] - v[0]) * sx
        + v[1] * (longint'(1) <<< (SHIFT_FRAC_BITS + 1));
    r  = round_half_up(n, 2 * SHIFT_FRAC_BITS + 2);
    lo = -(longint'(1) <<< PIXEL_BITS);
    hi = (longint'(1) <<< (PIXEL_BITS + 1)) - 1;
    if (r > hi) r = hi;
    if (r < lo) r = lo;
    return pix_out_t'(r);
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus construction.
  // ---------------------------------------------------------------------------

  function automatic window_t make_window(int xs, int ys, int unsigned px[9]);
    window_t w;
    w.x_shift = xs[FIELD_W-1:0];
    w.y_shift = ys[FIELD_W-1:0];
    w.p_r0c0  = px[0][FIELD_W-1:0];
    w.p_r0c1  = px[1][FIELD_W-1:0];
    w.p_r0c2  = px[2][FIELD_W-1:0];
    w.p_r1c0  = px[3][FIELD_W-1:0];
    w.p_r1c1  = px[4][FIELD_W-1:0];
    w.p_r1c2  = px[5][FIELD_W-1:0];
    w.p_r2c0  = px[6][FIELD_W-1:0];
    w.p_r2c1  = px[7][FIELD_W-1:0];
    w.p_r2c2  = px[8][FIELD_W-1:0];
    return w;
  endfunction

  // Mostly legal shifts, some raw 16-bit codes that must be clamped, and some
  // landmark values.
  function automatic int pick_shift();
    int roll;
    int marks[7];
    roll  = $urandom_range(99);
    marks = '{-SHIFT_ONE, -SHIFT_HALF, -1, 0, 1, SHIFT_HALF, SHIFT_ONE};
    if (roll < 70) return int'($urandom_range(2 * SHIFT_ONE)) - SHIFT_ONE;
    if (roll < 85) return int'($urandom_range(16'hFFFF));
    return marks[$urandom_range(6)];
  endfunction

  // Pixel windows: fully random, smooth neighborhoods, hard black and white
  // edges (worst overshoot), and values hugging both ends of the range.
  task automatic fill_pixels(output int unsigned px[9]);
    int          roll;
    int unsigned base;
    int          off;
    roll = $urandom_range(99);
    base = $urandom_range(PIX_MAX);
    for (int i = 0; i < 9; i++) begin
      if (roll < 50) begin
        px[i] = $urandom_range(PIX_MAX);
      end else if (roll < 75) begin
        off   = int'($urandom_range(512)) - 256;
        px[i] = (int'(base) + off < 0) ? 0 :
                (int'(base) + off > PIX_MAX) ? PIX_MAX : int'(base) + off;
      end else if (roll < 90) begin
        px[i] = $urandom_range(1) ? PIX_MAX : 0;
      end else begin
        case ($urandom_range(4))
          0:       px[i] = 0;
          1:       px[i] = 1;
          2:       px[i] = PIX_MAX - 1;
          3:       px[i] = PIX_MAX;
          default: px[i] = $urandom_range(PIX_MAX);
        endcase
      end
    end
  endtask

  task automatic queue_window(int xs, int ys, int unsigned px[9]);
    window_q.push_back(make_window(xs, ys, px));
  endtask

  // Hand-picked requests: shift extremes and clamping, flat, ramp and peaked
  // windows, and the strongest overshoot that 16-bit pixels can produce.
  task automatic build_directed();
    int unsigned px[9];
    px = '{default: 0};
    queue_window(0, 0, px);
    queue_window(SHIFT_ONE, -SHIFT_ONE, px);
    px = '{default: PIX_MAX};
    queue_window(0, 0, px);
    queue_window(SHIFT_ONE, SHIFT_ONE, px);
    queue_window(-SHIFT_ONE, -SHIFT_ONE, px);
    // Raw codes beyond plus and minus one must behave as the clamped ends.
    queue_window(16'h7FFF, 16'h8000, px);
    px = '{0, 8192, 16384, 24576, 32768, 40960, 49152, 57344, PIX_MAX};
    queue_window(SHIFT_ONE, -SHIFT_ONE, px);
    queue_window(SHIFT_ONE + 1, -SHIFT_ONE - 1, px);
    queue_window(-SHIFT_HALF, SHIFT_HALF - 1, px);
    px = '{0, 0, 0, 0, PIX_MAX, 0, 0, 0, 0};
    queue_window(SHIFT_HALF, SHIFT_HALF, px);
    queue_window(-1, 1, px);
    px = '{PIX_MAX, PIX_MAX, PIX_MAX, PIX_MAX, 0, PIX_MAX, PIX_MAX, PIX_MAX, PIX_MAX};
    queue_window(SHIFT_HALF, -SHIFT_HALF, px);
    // Step edge on two sides: the curve bulges above full scale near the corner.
    px = '{0, 0, 0, 0, PIX_MAX, PIX_MAX, 0, PIX_MAX, PIX_MAX};
    queue_window(SHIFT_HALF, SHIFT_HALF, px);
    px = '{PIX_MAX, PIX_MAX, PIX_MAX, PIX_MAX, 0, 0, PIX_MAX, 0, 0};
    queue_window(SHIFT_HALF, SHIFT_HALF, px);
    px = '{0, PIX_MAX, 0, PIX_MAX, 0, PIX_MAX, 0, PIX_MAX, 0};
    queue_window(SHIFT_ONE, 0, px);
    queue_window(SHIFT_HALF, SHIFT_HALF, px);
    px = '{16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA,
           16'h5555, 16'hAAAA};
    queue_window(16'h5555 - 16'h4000, -16'h2AAA, px);
    px = '{16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555,
           16'hAAAA, 16'h5555};
    queue_window(16'hAAAA, 16'h5555, px);
    for (int i = 0; i < 4; i++) begin
      fill_pixels(px);
      queue_window(pick_shift(), pick_shift(), px);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Idle schedule. The first stretch starves the sender lightly and the sink
  // heavily, the second swaps the two, and the last runs at full rate.
  // ---------------------------------------------------------------------------

  function automatic int unsigned send_idle_pct();
    if (accept_cnt < PHASE_ITEMS) return 25;
    if (accept_cnt < 2 * PHASE_ITEMS) return 67;
    return 0;
  endfunction

  function automatic int unsigned sink_idle_pct();
    if (accept_cnt < PHASE_ITEMS) return 67;
    if (accept_cnt < 2 * PHASE_ITEMS) return 25;
    return 0;
  endfunction

  // ---------------------------------------------------------------------------
  // Driver. Everything is sampled at the rising edge and driven with one
  // nonblocking assignment per signal, so the DUT sees stable inputs.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : drive_proc
    logic    nxt_valid;
    window_t nxt_win;
    if (!rst_ni) begin
      s_axis_tvalid_i <= 1'b0;
      s_axis_tdata_i  <= '0;
    end else begin
      nxt_valid = s_axis_tvalid_i;
      nxt_win   = window_t'(s_axis_tdata_i);
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        // The request was taken at this edge, so its answer is now owed.
        interp_q.push_back(interp_predict(window_t'(s_axis_tdata_i)));
        accept_cnt <= accept_cnt + 1;
        nxt_valid = 1'b0;
      end
      if (!nxt_valid && window_q.size() != 0 && $urandom_range(99) >= send_idle_pct()) begin
        nxt_win   = window_q.pop_front();
        nxt_valid = 1'b1;
      end
      s_axis_tvalid_i <= nxt_valid;
      s_axis_tdata_i  <= nxt_win;
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor. Each result taken is compared with the oldest owed pixel; the pad
  // bits above the value must read as zero.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : check_proc
    pix_out_t want;
    if (!rst_ni) begin
      m_axis_tready_i <= 1'b0;
    end else begin
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        if (interp_q.size() == 0) begin
          fail_cnt <= fail_cnt + 1;
          if (fail_cnt < MAX_REPORTS) begin
            $display("ERROR: result %0h with no request outstanding", m_axis_tdata_o);
          end
        end else begin
          want = interp_q.pop_front();
          if (m_axis_tdata_o[OUT_FIELD_W-1:0] !== want ||
              m_axis_tdata_o[M_TDATA_W-1:OUT_FIELD_W] !== '0) begin
            fail_cnt <= fail_cnt + 1;
            if (fail_cnt < MAX_REPORTS) begin
              $display("ERROR: interpolated_value expected %0d got %0d (pad %0h)",
                       $signed(want), $signed(m_axis_tdata_o[OUT_FIELD_W-1:0]),
                       m_axis_tdata_o[M_TDATA_W-1:OUT_FIELD_W]);
            end
          end
        end
      end
      m_axis_tready_i <= ($urandom_range(99) >= sink_idle_pct());
    end
  end

  // Watchdog against a hung handshake.
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("biquadratic_3x3_interpolator_unit verification failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence: build the request list, reset, let the driver drain it, wait for
  // every owed result plus a margin, then judge.
  // ---------------------------------------------------------------------------
  initial begin : main_proc
    int unsigned px[9];
    rst_ni          = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    m_axis_tready_i = 1'b0;
    accept_cnt      = 0;
    fail_cnt        = 0;
    cycle_cnt       = 0;
    build_directed();
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      fill_pixels(px);
      queue_window(pick_shift(), pick_shift(), px);
    end
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    while (window_q.size() != 0 || s_axis_tvalid_i || interp_q.size() != 0) begin
      @(posedge clk_i);
    end
    // Any stray result in this window is caught by the monitor.
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_cnt == 0 && interp_q.size() == 0) begin
      $display("biquadratic_3x3_interpolator_unit verification clean");
    end else begin
      $display("biquadratic_3x3_interpolator_unit verification failed");
    end
    $finish;
  end

endmodule
